// ===== hw/rtl/e2r_pkg.sv =====
// e2r_pkg: types, constants and helpers for the Euler-to-rotation-matrix core.
// No dependencies.
`default_nettype none
package e2r_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int WFRAC         = 30;
    localparam int TABLE_LEN     = 24;
    localparam int NSTG          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int QW            = 34;   // Q2.30 plus headroom

    localparam logic signed [QW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0]          PI_Q30   = 32'd3373259426;
    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;

    // Degrees to radians without a divider:
    // mag*PI/HALF_TURN = mag*PI_QUO + (mag*PI_REM)/HALF_TURN, and
    // HALF_TURN = 2^FOLD_SH * FOLD_DIV, the last step by reciprocal multiply.
    // RECIP_DIV = ceil(2^RECIP_SH / FOLD_DIV) is exact for operands below 2^19.
    localparam int PI_QUO    = int'(PI_Q30 / HALF_TURN);
    localparam int PI_REM    = int'(PI_Q30 % HALF_TURN);
    localparam int FOLD_SH   = 9;
    localparam int FOLD_DIV  = HALF_TURN >> FOLD_SH;
    localparam int RECIP_SH  = 25;
    localparam int RECIP_DIV = ((1 << RECIP_SH) + FOLD_DIV - 1) / FOLD_DIV;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } e2r_in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } e2r_out_t;

    // Classified angle: CORDIC start angle and negate flag.
    typedef struct packed {
        logic signed [QW-1:0] z;
        logic                 neg;
    } e2r_ang_t;

    typedef struct packed {
        e2r_ang_t r;
        e2r_ang_t p;
        e2r_ang_t y;
    } e2r_cls_t;

    function automatic logic signed [QW-1:0] atan_q30(input int i);
        logic signed [QW-1:0] t;
        begin
            unique case (i)
                0:  t = 34'sd843314857;
                1:  t = 34'sd497837829;
                2:  t = 34'sd263043837;
                3:  t = 34'sd133525159;
                4:  t = 34'sd67021687;
                5:  t = 34'sd33543516;
                6:  t = 34'sd16775851;
                7:  t = 34'sd8388437;
                8:  t = 34'sd4194283;
                9:  t = 34'sd2097149;
                default: t = QW'(34'sd1073741824 >>> i);
            endcase
            return t;
        end
    endfunction

    // Q30 product rounded back to Q30
    function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        begin
            p = a * b + (68'sd1 <<< (WFRAC - 1));
            return QW'(p >>> WFRAC);
        end
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] lim;
        begin
            v   = (q + (QW'(1) <<< (WFRAC - OUT_FRAC_BITS - 1))) >>> (WFRAC - OUT_FRAC_BITS);
            lim = QW'(1) <<< OUT_FRAC_BITS;
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            if (v > 34'sd32767) v = 34'sd32767;
            if (v < -34'sd32768) v = -34'sd32768;
            return v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/e2r_front.sv =====
// e2r_front: reduces each angle to [-90,90], converts to Q30 radians (registered).
// Depends on e2r_pkg.
`default_nettype none
module e2r_front
    import e2r_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire e2r_in_t  din,
    input  wire logic     din_vld,
    output e2r_cls_t      cls,
    output logic          cls_vld
);
    typedef struct packed {
        logic [13:0] mag;
        logic        sgn;
        logic        neg;
    } red_t;

    // whole-part product and remainder quotient input of the radian conversion
    typedef struct packed {
        logic [30:0] hi;
        logic [18:0] lo;
        logic        sgn;
        logic        neg;
    } mid_t;

    red_t red_reg [3], red_next [3];
    mid_t mid_reg [3];
    logic vld1_reg;
    logic vld2_reg;
    e2r_cls_t cls_reg;
    logic vld3_reg;

    function automatic red_t reduce(input logic signed [15:0] raw);
        logic signed [17:0] a;
        red_t r;
        begin
            a = 18'(raw);
            r.neg = 1'b0;
            if (a >= 18'sd23040) a = a - 18'sd46080;
            if (a < -18'sd23040) a = a + 18'sd46080;
            if (a > 18'sd11520) begin
                a = a - 18'sd23040; r.neg = 1'b1;
            end else if (a < -18'sd11520) begin
                a = a + 18'sd23040; r.neg = 1'b1;
            end
            r.sgn = a[17];
            r.mag = a[17] ? 14'(-a) : 14'(a);
            return r;
        end
    endfunction

    function automatic mid_t split(input red_t r);
        logic [27:0] t;
        mid_t m;
        begin
            m.hi  = 31'(r.mag) * 31'(PI_QUO);
            t     = 28'(r.mag) * 28'(PI_REM) + 28'(HALF_TURN / 2);
            m.lo  = 19'(t >> FOLD_SH);
            m.sgn = r.sgn;
            m.neg = r.neg;
            return m;
        end
    endfunction

    function automatic e2r_ang_t finish(input mid_t m);
        logic [38:0] q;
        logic [QW-1:0] z;
        e2r_ang_t o;
        begin
            q     = 39'(m.lo) * 39'(RECIP_DIV);
            z     = QW'(m.hi) + QW'(q >> RECIP_SH);
            o.z   = m.sgn ? -$signed(z) : $signed(z);
            o.neg = m.neg;
            return o;
        end
    endfunction

    assign red_next[0] = reduce(din.roll_angle);
    assign red_next[1] = reduce(din.pitch_angle);
    assign red_next[2] = reduce(din.yaw_angle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= din_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg    <= red_next;
            mid_reg[0] <= split(red_reg[0]);
            mid_reg[1] <= split(red_reg[1]);
            mid_reg[2] <= split(red_reg[2]);
            cls_reg.r  <= finish(mid_reg[0]);
            cls_reg.p  <= finish(mid_reg[1]);
            cls_reg.y  <= finish(mid_reg[2]);
        end
    end

    assign cls     = cls_reg;
    assign cls_vld = vld3_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_back.sv =====
// e2r_back: pipelined CORDIC for three angles, then product and output stages.
// Depends on e2r_pkg.
`default_nettype none
module e2r_back
    import e2r_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire e2r_cls_t cls,
    input  wire logic     cls_vld,
    output e2r_out_t      res,
    output logic          res_vld
);
    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic                 neg;
    } cst_t;

    cst_t cs_reg [NSTG+1][3];
    logic vld_reg [NSTG+4];

    // products
    logic signed [QW-1:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [QW-1:0] spsr_reg, spcr_reg, sr2_reg, cr2_reg, cp2_reg, sy2_reg, cy2_reg, sp2_reg;
    e2r_out_t out_reg;

    genvar g, k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_in
            e2r_ang_t a;
            assign a = (k == 0) ? cls.r : (k == 1) ? cls.p : cls.y;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cs_reg[0][k].x   <= GAIN_Q30;
                    cs_reg[0][k].y   <= '0;
                    cs_reg[0][k].z   <= a.z;
                    cs_reg[0][k].neg <= a.neg;
                end
            end
        end
        for (g = 0; g < NSTG; g++)
        begin : g_stg
            for (k = 0; k < 3; k++)
            begin : g_ax
                cst_t c;
                assign c = cs_reg[g][k];
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        cs_reg[g+1][k].neg <= c.neg;
                        if (!c.z[QW-1])
                        begin
                            cs_reg[g+1][k].x <= c.x - (c.y >>> g);
                            cs_reg[g+1][k].y <= c.y + (c.x >>> g);
                            cs_reg[g+1][k].z <= c.z - atan_q30(g);
                        end
                        else
                        begin
                            cs_reg[g+1][k].x <= c.x + (c.y >>> g);
                            cs_reg[g+1][k].y <= c.y - (c.x >>> g);
                            cs_reg[g+1][k].z <= c.z + atan_q30(g);
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG + 4; i++) vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= cls_vld;
            for (int i = 1; i < NSTG + 4; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // sign fix
            cr_reg <= cs_reg[NSTG][0].neg ? -cs_reg[NSTG][0].x : cs_reg[NSTG][0].x;
            sr_reg <= cs_reg[NSTG][0].neg ? -cs_reg[NSTG][0].y : cs_reg[NSTG][0].y;
            cp_reg <= cs_reg[NSTG][1].neg ? -cs_reg[NSTG][1].x : cs_reg[NSTG][1].x;
            sp_reg <= cs_reg[NSTG][1].neg ? -cs_reg[NSTG][1].y : cs_reg[NSTG][1].y;
            cy_reg <= cs_reg[NSTG][2].neg ? -cs_reg[NSTG][2].x : cs_reg[NSTG][2].x;
            sy_reg <= cs_reg[NSTG][2].neg ? -cs_reg[NSTG][2].y : cs_reg[NSTG][2].y;
            // first product
            spsr_reg <= mulq(sp_reg, sr_reg);
            spcr_reg <= mulq(sp_reg, cr_reg);
            sr2_reg <= sr_reg; cr2_reg <= cr_reg; cp2_reg <= cp_reg;
            sp2_reg <= sp_reg; sy2_reg <= sy_reg; cy2_reg <= cy_reg;
            // second products, sums and output rounding
            out_reg.m00 <= to_out(mulq(cy2_reg, cp2_reg));
            out_reg.m01 <= to_out(mulq(cy2_reg, spsr_reg) - mulq(sy2_reg, cr2_reg));
            out_reg.m02 <= to_out(mulq(cy2_reg, spcr_reg) + mulq(sy2_reg, sr2_reg));
            out_reg.m10 <= to_out(mulq(sy2_reg, cp2_reg));
            out_reg.m11 <= to_out(mulq(sy2_reg, spsr_reg) + mulq(cy2_reg, cr2_reg));
            out_reg.m12 <= to_out(mulq(sy2_reg, spcr_reg) - mulq(cy2_reg, sr2_reg));
            out_reg.m20 <= to_out(-sp2_reg);
            out_reg.m21 <= to_out(mulq(cp2_reg, sr2_reg));
            out_reg.m22 <= to_out(mulq(cp2_reg, cr2_reg));
        end
    end

    assign res     = out_reg;
    assign res_vld = vld_reg[NSTG+3];
endmodule
`default_nettype wire

// ===== hw/rtl/euler_to_rotation_matrix_core.sv =====
// Euler ZYX angles to 3x3 rotation matrix, R = Rz(yaw)*Ry(pitch)*Rx(roll).
// Pipeline: NSTG+8 register stages (3 front, 1 queue, NSTG+4 back).
// Throughput: one transaction per cycle while in_stall is low. A two-entry queue
// splits front and back; the back holds only on a stalled result, the front only
// when the queue is full.
// Reset: asynchronous active-low rst_n clears valid bits and queue pointers.
`default_nettype none
module euler_to_rotation_matrix_core
    import e2r_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire e2r_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output e2r_out_t      out_data
);
    e2r_cls_t cls;
    logic     cls_vld;
    logic     en_front;
    logic     en_back;

    // front-to-back queue
    e2r_cls_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    e2r_cls_t   q_head;

    // Back moves unless its result is held; it takes the queue head when one is there.
    assign en_back  = !(out_valid && out_stall);
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop      = en_back && !empty;
    // Front holds only when its finished transaction cannot enter the queue.
    assign en_front = !(cls_vld && full && !pop);
    assign push     = cls_vld && en_front;
    assign in_stall = !en_front;
    assign q_head   = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // When full, a write lands on the slot being popped in the same cycle.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    e2r_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en_front),
        .din     (in_data),
        .din_vld (in_valid),
        .cls     (cls),
        .cls_vld (cls_vld)
    );

    e2r_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en_back),
        .cls     (q_head),
        .cls_vld (pop),
        .res     (out_data),
        .res_vld (out_valid)
    );
endmodule
`default_nettype wire
